// File: design/cdq_pkg.sv
// Package for the circular deque: field widths, command/status/op codes
// and the item that travels from the front decoder to the back engine.
// No dependencies.
package cdq_pkg;

  // Default number of stored words
  localparam int unsigned DepthDef   = 8;
  // Entries of the op queue between front and back
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned DataW = 32;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned StatW = 3;
  localparam int unsigned AddrW = 2;
  localparam int unsigned PDataW = 32;

  // Byte address of the restrict_mode register
  localparam logic [AddrW-1:0] RegRestrictAddr = 2'd0;

  typedef enum logic [CmdW-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_BACK  = 3'd3,
    CMD_DUMP      = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK          = 3'd0,
    ST_OVERFLOW    = 3'd1,
    ST_UNDERFLOW   = 3'd2,
    ST_EMPTY       = 3'd3,
    ST_NOT_ALLOWED = 3'd4
  } status_e;

  typedef enum logic {
    MODE_IN_RESTRICT  = 1'b0,  // front insert refused
    MODE_OUT_RESTRICT = 1'b1   // back delete refused
  } mode_e;

  // Operation after decoding and the mode check
  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_BACK  = 3'd3,
    OP_DUMP      = 3'd4,
    OP_REFUSE    = 3'd5
  } op_e;

  typedef struct packed {
    op_e                     kind;
    logic signed [DataW-1:0] value;
  } op_t;

endpackage

// File: design/cdq_if.sv
// Valid/ready channel interfaces for the circular deque: command words in,
// result words out. Depends on cdq_pkg.
interface cdq_cmd_if import cdq_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CmdW-1:0]         cmd;
  logic signed [DataW-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface cdq_res_if import cdq_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [StatW-1:0]        status;
  logic signed [DataW-1:0] data;
  logic                    last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

// File: design/cdq_front.sv
// Front decoder of the circular deque: accepts command words, applies the
// restrict mode and pushes one op into the op queue. Depends on cdq_pkg, cdq_if.
module cdq_front import cdq_pkg::*; (
  cdq_cmd_if.sink cmd_i,
  input  mode_e   mode_i,
  input  logic    full_i,
  output logic    push_o,
  output op_t     op_o
);

  // Accept whenever the op queue has room
  assign cmd_i.ready = !full_i;
  assign push_o      = cmd_i.valid && !full_i;

  // Classify the command; refused and unknown codes become one refusal op
  always_comb begin
    op_o.value = cmd_i.value;
    unique case (cmd_i.cmd)
      CMD_INS_FRONT: begin
        op_o.kind = (mode_i == MODE_IN_RESTRICT) ? OP_REFUSE : OP_INS_FRONT;
      end
      CMD_INS_BACK:  op_o.kind = OP_INS_BACK;
      CMD_DEL_FRONT: op_o.kind = OP_DEL_FRONT;
      CMD_DEL_BACK: begin
        op_o.kind = (mode_i == MODE_OUT_RESTRICT) ? OP_REFUSE : OP_DEL_BACK;
      end
      CMD_DUMP:      op_o.kind = OP_DUMP;
      default:       op_o.kind = OP_REFUSE;
    endcase
  end

endmodule

// File: design/cdq_queue.sv
// Small op queue between the front decoder and the back engine.
// Depends on cdq_pkg.
module cdq_queue import cdq_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  op_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  op_t             entry_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign op_o    = entry_q[rd_q];

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed ops
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= op_i;
    end
  end

endmodule

// File: design/cdq_back.sv
// Back engine of the circular deque: owns the slot memory, the front/back
// indices and the fill count, runs each op and drives the result register.
// Depends on cdq_pkg, cdq_if.
module cdq_back import cdq_pkg::*; #(
  parameter int unsigned Depth = DepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  op_t        op_i,
  input  logic       empty_i,
  output logic       pop_o,
  cdq_res_if.source  res_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
  localparam logic [CntW-1:0] OneCnt  = CntW'(1);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_DEL      = 4'b0010,
    S_DUMP_RD  = 4'b0100,
    S_DUMP_OUT = 4'b1000
  } state_e;

  function automatic logic [IdxW-1:0] idx_next(input logic [IdxW-1:0] i);
    return (i == LastIdx) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_prev(input logic [IdxW-1:0] i);
    return (i == '0) ? LastIdx : i - 1'b1;
  endfunction

  state_e          state_q, state_d;
  logic [IdxW-1:0] front_q, front_d, back_q, back_d, walk_q, walk_d;
  logic [CntW-1:0] fill_q, fill_d, left_q, left_d;
  logic            ov_q, ov_d;
  status_e         status_q, status_d;
  logic signed [DataW-1:0] data_q, data_d;
  logic            last_q, last_d;

  logic [DataW-1:0] slot_q [Depth];
  logic [DataW-1:0] rdata_q;
  logic             we, re;
  logic [IdxW-1:0]  waddr, raddr;

  logic    out_free;
  logic    load;
  status_e ld_status;
  logic signed [DataW-1:0] ld_data;
  logic    ld_last;

  assign out_free = !ov_q || res_o.ready;

  // Sequence one op: single results, delete read, dump walk
  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    back_d    = back_q;
    walk_d    = walk_q;
    fill_d    = fill_q;
    left_d    = left_q;
    we        = 1'b0;
    waddr     = front_q;
    re        = 1'b0;
    raddr     = front_q;
    pop_o     = 1'b0;
    load      = 1'b0;
    ld_status = ST_OK;
    ld_data   = '0;
    ld_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o = 1'b1;
          unique case (op_i.kind)
            OP_INS_FRONT, OP_INS_BACK: begin
              load = 1'b1;
              if (fill_q == FullCnt) begin
                ld_status = ST_OVERFLOW;
              end else begin
                we     = 1'b1;
                fill_d = fill_q + 1'b1;
                if (fill_q == '0) begin
                  front_d = '0;
                  back_d  = '0;
                  waddr   = '0;
                end else if (op_i.kind == OP_INS_FRONT) begin
                  front_d = idx_prev(front_q);
                  waddr   = idx_prev(front_q);
                end else begin
                  back_d = idx_next(back_q);
                  waddr  = idx_next(back_q);
                end
              end
            end
            OP_DEL_FRONT, OP_DEL_BACK: begin
              if (fill_q == '0) begin
                load      = 1'b1;
                ld_status = ST_UNDERFLOW;
              end else begin
                re      = 1'b1;
                raddr   = (op_i.kind == OP_DEL_FRONT) ? front_q : back_q;
                fill_d  = fill_q - 1'b1;
                state_d = S_DEL;
                if (fill_q == OneCnt) begin
                  front_d = '0;
                  back_d  = '0;
                end else if (op_i.kind == OP_DEL_FRONT) begin
                  front_d = idx_next(front_q);
                end else begin
                  back_d = idx_prev(back_q);
                end
              end
            end
            OP_DUMP: begin
              if (fill_q == '0) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                walk_d  = front_q;
                left_d  = fill_q;
                state_d = S_DUMP_RD;
              end
            end
            default: begin
              load      = 1'b1;
              ld_status = ST_NOT_ALLOWED;
            end
          endcase
        end
      end
      S_DEL: begin
        if (out_free) begin
          load    = 1'b1;
          ld_data = rdata_q;
          state_d = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        re      = 1'b1;
        raddr   = walk_q;
        walk_d  = idx_next(walk_q);
        state_d = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (out_free) begin
          load    = 1'b1;
          ld_data = rdata_q;
          ld_last = (left_q == OneCnt);
          left_d  = left_q - 1'b1;
          state_d = (left_q == OneCnt) ? S_IDLE : S_DUMP_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result register: load a new word or drop the one taken
  always_comb begin
    ov_d     = ov_q;
    status_d = status_q;
    data_d   = data_q;
    last_d   = last_q;
    if (ov_q && res_o.ready) begin
      ov_d = 1'b0;
    end
    if (load) begin
      ov_d     = 1'b1;
      status_d = ld_status;
      data_d   = ld_data;
      last_d   = ld_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      back_q  <= '0;
      walk_q  <= '0;
      fill_q  <= '0;
      left_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      back_q  <= back_d;
      walk_q  <= walk_d;
      fill_q  <= fill_d;
      left_q  <= left_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    data_q   <= data_d;
    last_q   <= last_d;
  end

  // Slot memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      slot_q[waddr] <= op_i.value;
    end
    if (re) begin
      rdata_q <= slot_q[raddr];
    end
  end

  assign res_o.valid  = ov_q;
  assign res_o.status = status_q;
  assign res_o.data   = data_q;
  assign res_o.last   = last_q;

endmodule

// File: design/circular_deque_top.sv
// Circular deque top: APB register, front decoder, op queue, back engine.
// A command passes the op queue, then the result register; a delete also passes
// the registered slot read. Insert, refusal and error results: 1 per cycle while
// results are taken. Delete and dump hold the next op; dump reads each word in turn.
// Reset clears indices, fill count, queues and restrict_mode; slots keep their
// contents (only written slots are read), so no clearing pass is needed.
module circular_deque_top import cdq_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cdq_cmd_if.sink           cmd_i,
  cdq_res_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata,
  output logic              pready
);

  mode_e mode_q, mode_d;
  logic  push, q_full, pop, q_empty;
  op_t   op_f, op_b;

  // Restrict mode register
  assign pready = 1'b1;

  always_comb begin
    mode_d = mode_q;
    if (psel && penable && pwrite && (paddr == RegRestrictAddr)) begin
      mode_d = mode_e'(pwdata[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IN_RESTRICT;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign prdata = (paddr == RegRestrictAddr) ? {{(PDataW-1){1'b0}}, mode_q} : '0;

  cdq_front u_front (
    .cmd_i  (cmd_i),
    .mode_i (mode_q),
    .full_i (q_full),
    .push_o (push),
    .op_o   (op_f)
  );

  cdq_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op_f),
    .full_o  (q_full),
    .pop_i   (pop),
    .op_o    (op_b),
    .empty_o (q_empty)
  );

  cdq_back #(
    .Depth (DEPTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (op_b),
    .empty_i (q_empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full))
    else $error("op pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_empty))
    else $error("op popped from an empty queue");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status != ST_OK)) |-> (res_o.last && (res_o.data == '0)))
    else $error("error result not final or carries data");

endmodule

// File: verif/cdq_checker.sv
`timescale 1ns / 100ps
// Result checker for the circular deque. It watches the command, result and register
// channels, predicts every result word and compares results in order.
// Depends on cdq_pkg and the channel interfaces in cdq_if.
module cdq_checker import cdq_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cdq_cmd_if                cmd_i,
  cdq_res_if                res_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [AddrW-1:0]  paddr,
  input  logic [PDataW-1:0] pwdata,
  output int unsigned       err_count_o,
  output int unsigned       pending_o,
  output int unsigned       cmd_count_o,
  output int unsigned       word_count_o
);

  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] data;
    logic                    last;
  } result_t;

  result_t                 expected_words[$];
  logic signed [DataW-1:0] slot_mem [DEPTH];
  int unsigned             front_pos = 0;
  int unsigned             back_pos = 0;
  int unsigned             fill = 0;
  mode_e                   mode = MODE_IN_RESTRICT;
  int unsigned             errors = 0;
  int unsigned             cmds_seen = 0;
  int unsigned             words_seen = 0;

  function automatic int unsigned wrap_up(int unsigned i);
    return (i + 1 >= DEPTH) ? 0 : i + 1;
  endfunction

  function automatic int unsigned wrap_down(int unsigned i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  // Queue the single closing word of a command
  task automatic queue_single(status_e st, logic signed [DataW-1:0] d);
    expected_words.push_back('{st, d, 1'b1});
  endtask

  // Advance the deque copy by one command and queue the words it yields
  task automatic apply_command(logic [CmdW-1:0] code, logic signed [DataW-1:0] word);
    logic signed [DataW-1:0] taken;
    int unsigned             pos;
    case (code)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (code == CMD_INS_FRONT && mode == MODE_IN_RESTRICT) begin
          queue_single(ST_NOT_ALLOWED, '0);
        end else if (fill >= DEPTH) begin
          queue_single(ST_OVERFLOW, '0);
        end else begin
          // an empty deque restarts at slot zero whichever end is used
          if (fill == 0) begin
            front_pos = 0;
            back_pos = 0;
            slot_mem[0] = word;
          end else if (code == CMD_INS_FRONT) begin
            front_pos = wrap_down(front_pos);
            slot_mem[front_pos] = word;
          end else begin
            back_pos = wrap_up(back_pos);
            slot_mem[back_pos] = word;
          end
          fill++;
          queue_single(ST_OK, '0);
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK: begin
        if (code == CMD_DEL_BACK && mode == MODE_OUT_RESTRICT) begin
          queue_single(ST_NOT_ALLOWED, '0);
        end else if (fill == 0) begin
          queue_single(ST_UNDERFLOW, '0);
        end else begin
          if (code == CMD_DEL_FRONT) begin
            taken = slot_mem[front_pos];
            front_pos = wrap_up(front_pos);
          end else begin
            taken = slot_mem[back_pos];
            back_pos = wrap_down(back_pos);
          end
          fill--;
          if (fill == 0) begin
            front_pos = 0;
            back_pos = 0;
          end
          queue_single(ST_OK, taken);
        end
      end
      CMD_DUMP: begin
        if (fill == 0) begin
          queue_single(ST_EMPTY, '0);
        end else begin
          pos = front_pos;
          for (int unsigned k = 0; k < fill; k++) begin
            expected_words.push_back('{ST_OK, slot_mem[pos], (k + 1 == fill)});
            pos = wrap_up(pos);
          end
        end
      end
      default: queue_single(ST_NOT_ALLOWED, '0);
    endcase
  endtask

  // Compare one accepted result word with the oldest prediction
  task automatic check_word();
    result_t want;
    if (expected_words.size() == 0) begin
      errors++;
      $display("%0t: unexpected word: expected none, got status %0d data %0d last %0b",
               $time, res_i.status, res_i.data, res_i.last);
    end else begin
      want = expected_words.pop_front();
      if (res_i.status !== want.status || res_i.data !== want.data ||
          res_i.last !== want.last) begin
        errors++;
        $display("%0t: word mismatch: expected status %0d data %0d last %0b", $time,
                 want.status, want.data, want.last);
        $display("%0t:                got status %0d data %0d last %0b", $time,
                 res_i.status, res_i.data, res_i.last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_words.delete();
      front_pos = 0;
      back_pos = 0;
      fill = 0;
      mode = MODE_IN_RESTRICT;
    end else begin
      // match results first: a word taken at this edge cannot come from a command taken here
      if (res_i.valid && res_i.ready) begin
        words_seen++;
        check_word();
      end
      if (psel && penable && pwrite && pready && paddr == RegRestrictAddr) begin
        mode = mode_e'(pwdata[0]);
      end
      if (cmd_i.valid && cmd_i.ready) begin
        cmds_seen++;
        apply_command(cmd_i.cmd, cmd_i.value);
      end
    end
    err_count_o  <= errors;
    pending_o    <= expected_words.size();
    cmd_count_o  <= cmds_seen;
    word_count_o <= words_seen;
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Top of the circular deque testbench: clock, reset, command and register stimulus,
// result backpressure and the verdict. Depends on cdq_pkg, cdq_if, cdq_checker.
module testbench;
  import cdq_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned PhaseCount  = 6;
  localparam int unsigned PhaseItems  = 40;
  localparam int unsigned QuietPhase  = 3;

  localparam logic [CmdW-1:0]         CmdUnknownLo = 3'd5;
  localparam logic [CmdW-1:0]         CmdUnknownHi = 3'd7;
  localparam logic signed [DataW-1:0] WordMax      = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] WordMin      = 32'sh80000000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic              pready;

  int unsigned err_count;
  int unsigned pending;
  int unsigned cmd_count;
  int unsigned word_count;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          no_idle = 1'b0;

  cdq_cmd_if cmd_if ();
  cdq_res_if res_if ();

  circular_deque_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cdq_checker deque_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_if),
    .res_i        (res_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .err_count_o  (err_count),
    .pending_o    (pending),
    .cmd_count_o  (cmd_count),
    .word_count_o (word_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Stop a hung run
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("testbench: done, errors");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned draw_gap();
    int unsigned r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Fill phases lean on inserts, drain phases on deletes
  function automatic logic [CmdW-1:0] pick_cmd(bit drain);
    int unsigned r = $urandom_range(0, 99);
    if (!drain) begin
      if (r < 30) return CMD_INS_FRONT;
      if (r < 65) return CMD_INS_BACK;
      if (r < 75) return CMD_DEL_FRONT;
      if (r < 85) return CMD_DEL_BACK;
      if (r < 95) return CMD_DUMP;
    end else begin
      if (r < 10) return CMD_INS_FRONT;
      if (r < 20) return CMD_INS_BACK;
      if (r < 50) return CMD_DEL_FRONT;
      if (r < 80) return CMD_DEL_BACK;
      if (r < 93) return CMD_DUMP;
    end
    return CmdW'($urandom_range(CmdUnknownLo, CmdUnknownHi));
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    int unsigned r = $urandom_range(0, 19);
    case (r)
      0: return WordMax;
      1: return WordMin;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Offer one command word, hold it until taken, then maybe idle
  task automatic send_word(logic [CmdW-1:0] code, logic signed [DataW-1:0] word);
    int unsigned gap;
    cmd_if.valid <= 1'b1;
    cmd_if.cmd   <= code;
    cmd_if.value <= word;
    do @(posedge clk_i); while (!cmd_if.ready);
    gap = no_idle ? 0 : draw_gap();
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      cmd_if.cmd   <= CmdW'($urandom);
      cmd_if.value <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off until every predicted word has come back, then let the pipe settle
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write restrict_mode: setup cycle, then access until pready
  task automatic write_mode(mode_e m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegRestrictAddr;
    pwdata  <= PDataW'(m);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result backpressure
  initial begin
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall_left != 0 && !no_idle) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        stall_left = no_idle ? 0 : draw_gap();
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.cmd   = CMD_DUMP;
    cmd_if.value = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty deque, refusals and unknown codes in input-restricted mode
    send_word(CMD_DUMP, '0);
    send_word(CMD_DEL_FRONT, '0);
    send_word(CMD_DEL_BACK, '0);
    send_word(CMD_INS_FRONT, WordMax);
    send_word(CmdUnknownLo, '0);
    send_word(CmdUnknownHi, '1);
    // insert into empty, then delete the only word
    send_word(CMD_INS_BACK, 32'sd123);
    send_word(CMD_DEL_BACK, '0);
    // fill to the top with extreme words, overflow, dump it all
    send_word(CMD_INS_BACK, WordMax);
    send_word(CMD_INS_BACK, WordMin);
    send_word(CMD_INS_BACK, '0);
    send_word(CMD_INS_BACK, '1);
    send_word(CMD_INS_BACK, 32'sh55555555);
    send_word(CMD_INS_BACK, 32'shaaaaaaaa);
    send_word(CMD_INS_BACK, 32'sd1);
    send_word(CMD_INS_BACK, $urandom);
    send_word(CMD_INS_BACK, 32'sd7);
    send_word(CMD_DUMP, '0);
    send_word(CMD_DEL_BACK, '0);
    send_word(CMD_DEL_FRONT, '0);

    // Output-restricted mode: front insert allowed, back delete refused
    wait_idle();
    write_mode(MODE_OUT_RESTRICT);
    send_word(CMD_INS_FRONT, WordMin);
    send_word(CMD_DEL_BACK, '0);
    send_word(CMD_DUMP, '0);

    // Random phases, alternating fill and drain, each under a fresh mode
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      wait_idle();
      write_mode(mode_e'($urandom_range(0, 1)));
      no_idle = (phase == QuietPhase);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        send_word(pick_cmd(phase[0]), pick_value());
      end
    end
    no_idle = 1'b0;
    wait_idle();

    $display("covered %0d commands and %0d result words across both restrict modes,",
             cmd_count, word_count);
    $display("empty, full, refused and unknown commands, with and without idling");
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
